@@ hw/rtl/srs_pkg.sv @@
package srs_pkg;

    // Operation codes of a request
    localparam logic [2:0] OP_STORE      = 3'd0;
    localparam logic [2:0] OP_DELETE     = 3'd1;
    localparam logic [2:0] OP_RECALL     = 3'd2;
    localparam logic [2:0] OP_GET_STATUS = 3'd3;
    localparam logic [2:0] OP_GET_REG    = 3'd4;

    // Reply status codes
    localparam logic [1:0] ST_SUCCESS   = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Reply kinds
    localparam logic KIND_SCENE    = 1'b0;
    localparam logic KIND_REGISTER = 1'b1;

    // Recall deduplication window and time range
    localparam logic [47:0] KEY_WINDOW_MS = 48'd6000;
    localparam logic [47:0] TIME_MAX      = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  operation;
        logic        acknowledged;
        logic [15:0] scene_id;
        logic [7:0]  transaction_id;
        logic [15:0] src_addr;
        logic [15:0] dst_addr;
        logic [47:0] now_ms;
    } t_in_req;

    typedef struct packed {
        logic        reply_kind;
        logic [1:0]  status;
        logic [15:0] current_scene_out;
        logic        entry_valid;
        logic [15:0] listed_scene;
        logic        last;
    } t_out_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_ACT,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_EMIT_SCENE,
        S_LIST_START,
        S_LIST_RD,
        S_LIST_OUT
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT,
        IDX_POS,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1
    } t_rd_sel;

    typedef enum logic {
        WR_NUM,
        WR_RDATA
    } t_wr_sel;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        t_idx_op    idx_op;
        logic       pos_load;
        logic       found_load;
        logic       found_val;
        logic       rd_en;
        t_rd_sel    rd_sel;
        logic       wr_en;
        t_wr_sel    wr_sel;
        logic       count_inc;
        logic       count_dec;
        logic       cur_set_num;
        logic       cur_clear_match;
        logic       status_load;
        logic [1:0] status_val;
        logic       recall_do;
        logic       out_load;
        logic       out_kind;
        logic       out_entry;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [2:0] op;
        logic       ack;
        logic       num_zero;
        logic       idx_eq_count;
        logic       idx_eq_pos;
        logic       idx_last;
        logic       rd_eq_num;
        logic       rd_gt_num;
        logic       found;
        logic       full;
        logic       count_zero;
        logic       out_free;
    } t_dp_sts;

endpackage

@@ hw/rtl/srs_datapath.sv @@
module srs_datapath
    import srs_pkg::*;
#(
    parameter int SCENE_MAX = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_req  i_in_data,
    input  logic     i_out_stall,
    input  t_dp_cmd  i_cmd,
    output t_dp_sts  o_sts,
    output logic     o_out_valid,
    output t_out_res o_out_data
);

    localparam int CW = $clog2(SCENE_MAX + 1);
    localparam int AW = (SCENE_MAX > 1) ? $clog2(SCENE_MAX) : 1;

    // Scene table storage
    logic [15:0] r_mem [SCENE_MAX];
    logic [15:0] r_rd_data;

    t_in_req     r_req;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_count, n_count;
    logic          r_found;
    logic [1:0]    r_status, n_status;
    logic [15:0]   r_current, n_current;
    logic          r_key_valid;
    logic [15:0]   r_last_src;
    logic [15:0]   r_last_dst;
    logic [7:0]    r_last_tid;
    logic [47:0]   r_key_expiry;
    logic          r_out_valid, n_out_valid;
    t_out_res      r_out;

    logic [CW-1:0] idx_m1, idx_p1;
    logic [CW:0]   idx_p1_wide;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [15:0]   wr_data;
    logic          key_same;
    logic [47:0]   exp_new;
    logic          out_free;

    assign idx_m1      = r_idx - CW'(1);
    assign idx_p1      = r_idx + CW'(1);
    assign idx_p1_wide = {1'b0, r_idx} + (CW + 1)'(1);
    assign out_free    = !r_out_valid || !i_out_stall;

    // Select table addresses
    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
            RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
            default:   rd_addr = r_idx[AW-1:0];
        endcase
    end
    assign wr_addr = r_idx[AW-1:0];
    assign wr_data = (i_cmd.wr_sel == WR_NUM) ? r_req.scene_id : r_rd_data;

    // Write and read the table, read data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Capture the request and hold scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_data;
        end
        r_idx    <= n_idx;
        r_status <= n_status;
        if (i_cmd.pos_load) begin
            r_pos <= r_idx;
        end
        if (i_cmd.found_load) begin
            r_found <= i_cmd.found_val;
        end
    end

    always_comb begin
        case (i_cmd.idx_op)
            IDX_ZERO:  n_idx = '0;
            IDX_COUNT: n_idx = r_count;
            IDX_POS:   n_idx = r_pos;
            IDX_INC:   n_idx = idx_p1;
            IDX_DEC:   n_idx = idx_m1;
            default:   n_idx = r_idx;
        endcase
    end

    // Match the recall against the stored transaction key
    assign key_same = r_key_valid
                   && (r_last_src == r_req.src_addr)
                   && (r_last_dst == r_req.dst_addr)
                   && (r_last_tid == r_req.transaction_id)
                   && (r_req.now_ms <= r_key_expiry);
    assign exp_new = (r_req.now_ms > (TIME_MAX - KEY_WINDOW_MS))
                   ? TIME_MAX : (r_req.now_ms + KEY_WINDOW_MS);

    // Next count, current scene and status
    always_comb begin
        n_count = r_count;
        if (i_cmd.count_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.count_dec) begin
            n_count = r_count - CW'(1);
        end

        n_current = r_current;
        if (i_cmd.cur_set_num) begin
            n_current = r_req.scene_id;
        end else if (i_cmd.cur_clear_match && (r_current == r_req.scene_id)) begin
            n_current = '0;
        end else if (i_cmd.recall_do && !key_same && r_found) begin
            n_current = r_req.scene_id;
        end

        n_status = r_status;
        if (i_cmd.status_load) begin
            n_status = i_cmd.status_val;
        end else if (i_cmd.recall_do) begin
            n_status = r_found ? ST_SUCCESS : ST_NOT_FOUND;
        end
    end

    // Scene state and transaction key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_current    <= '0;
            r_key_valid  <= 1'b0;
            r_last_src   <= '0;
            r_last_dst   <= '0;
            r_last_tid   <= '0;
            r_key_expiry <= '0;
        end else begin
            r_count   <= n_count;
            r_current <= n_current;
            if (i_cmd.recall_do) begin
                r_key_expiry <= exp_new;
                if (!key_same) begin
                    r_key_valid <= 1'b1;
                    r_last_src  <= r_req.src_addr;
                    r_last_dst  <= r_req.dst_addr;
                    r_last_tid  <= r_req.transaction_id;
                end
            end
        end
    end

    // Output register: load a result, drop it once taken
    always_comb begin
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.reply_kind        <= i_cmd.out_kind;
            r_out.status            <= r_status;
            r_out.current_scene_out <= r_current;
            r_out.entry_valid       <= i_cmd.out_entry;
            r_out.listed_scene      <= i_cmd.out_entry ? r_rd_data : 16'd0;
            r_out.last              <= i_cmd.out_entry
                                       ? (idx_p1_wide >= {1'b0, r_count}) : 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status toward the controller
    always_comb begin
        o_sts.op           = r_req.operation;
        o_sts.ack          = r_req.acknowledged;
        o_sts.num_zero     = (r_req.scene_id == 16'd0);
        o_sts.idx_eq_count = (r_idx == r_count);
        o_sts.idx_eq_pos   = (r_idx == r_pos);
        o_sts.idx_last     = (idx_p1_wide >= {1'b0, r_count});
        o_sts.rd_eq_num    = (r_rd_data == r_req.scene_id);
        o_sts.rd_gt_num    = (r_rd_data > r_req.scene_id);
        o_sts.found        = r_found;
        o_sts.full         = (r_count == CW'(SCENE_MAX));
        o_sts.count_zero   = (r_count == '0);
        o_sts.out_free     = out_free;
    end

endmodule

@@ hw/rtl/srs_ctrl.sv @@
module srs_ctrl
    import srs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.idx_op = IDX_HOLD;
        o_cmd.rd_sel = RD_IDX;
        o_cmd.wr_sel = WR_NUM;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                unique case (i_sts.op) inside
                    OP_GET_STATUS: begin
                        o_cmd.status_load = 1'b1;
                        o_cmd.status_val  = ST_SUCCESS;
                        n_state = S_EMIT_SCENE;
                    end
                    OP_GET_REG: begin
                        o_cmd.status_load = 1'b1;
                        o_cmd.status_val  = ST_SUCCESS;
                        n_state = S_LIST_START;
                    end
                    OP_STORE, OP_DELETE, OP_RECALL: begin
                        if (i_sts.num_zero) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.idx_op = IDX_ZERO;
                            n_state = S_SCAN_RD;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end

            // Walk the sorted table up to the first entry not below the number
            S_SCAN_RD: begin
                if (i_sts.idx_eq_count) begin
                    o_cmd.found_load = 1'b1;
                    o_cmd.found_val  = 1'b0;
                    o_cmd.pos_load   = 1'b1;
                    n_state = S_ACT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                    n_state = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP: begin
                if (i_sts.rd_eq_num || i_sts.rd_gt_num) begin
                    o_cmd.found_load = 1'b1;
                    o_cmd.found_val  = i_sts.rd_eq_num;
                    o_cmd.pos_load   = 1'b1;
                    n_state = S_ACT;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state = S_SCAN_RD;
                end
            end

            S_ACT: begin
                if (i_sts.op == OP_STORE) begin
                    o_cmd.status_load = 1'b1;
                    if (i_sts.found) begin
                        o_cmd.status_val  = ST_SUCCESS;
                        o_cmd.cur_set_num = 1'b1;
                        n_state = i_sts.ack ? S_LIST_START : S_IDLE;
                    end else if (i_sts.full) begin
                        o_cmd.status_val = ST_FULL;
                        n_state = i_sts.ack ? S_LIST_START : S_IDLE;
                    end else begin
                        o_cmd.status_val = ST_SUCCESS;
                        o_cmd.idx_op     = IDX_COUNT;
                        n_state = S_UP_RD;
                    end
                end else if (i_sts.op == OP_DELETE) begin
                    o_cmd.status_load = 1'b1;
                    o_cmd.status_val  = ST_SUCCESS;
                    if (i_sts.found) begin
                        o_cmd.idx_op = IDX_POS;
                        n_state = S_DN_RD;
                    end else begin
                        n_state = i_sts.ack ? S_LIST_START : S_IDLE;
                    end
                end else begin
                    o_cmd.recall_do = 1'b1;
                    n_state = i_sts.ack ? S_EMIT_SCENE : S_IDLE;
                end
            end

            // Shift entries up from the end to open the insertion slot
            S_UP_RD: begin
                if (i_sts.idx_eq_pos) begin
                    o_cmd.wr_en       = 1'b1;
                    o_cmd.wr_sel      = WR_NUM;
                    o_cmd.count_inc   = 1'b1;
                    o_cmd.cur_set_num = 1'b1;
                    n_state = i_sts.ack ? S_LIST_START : S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_M1;
                    n_state = S_UP_WR;
                end
            end

            S_UP_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_RDATA;
                o_cmd.idx_op = IDX_DEC;
                n_state = S_UP_RD;
            end

            // Shift entries down over the deleted slot
            S_DN_RD: begin
                if (i_sts.idx_last) begin
                    o_cmd.count_dec       = 1'b1;
                    o_cmd.cur_clear_match = 1'b1;
                    n_state = i_sts.ack ? S_LIST_START : S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_P1;
                    n_state = S_DN_WR;
                end
            end

            S_DN_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_RDATA;
                o_cmd.idx_op = IDX_INC;
                n_state = S_DN_RD;
            end

            S_EMIT_SCENE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_kind  = KIND_SCENE;
                    o_cmd.out_entry = 1'b0;
                    n_state = S_IDLE;
                end
            end

            // List the register, one result per entry, or one empty result when none is held
            S_LIST_START: begin
                if (i_sts.count_zero) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load  = 1'b1;
                        o_cmd.out_kind  = KIND_REGISTER;
                        o_cmd.out_entry = 1'b0;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.idx_op = IDX_ZERO;
                    n_state = S_LIST_RD;
                end
            end

            S_LIST_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_IDX;
                n_state = S_LIST_OUT;
            end

            S_LIST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_kind  = KIND_REGISTER;
                    o_cmd.out_entry = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_op = IDX_INC;
                        n_state = S_LIST_RD;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/scene_register_server_core.sv @@
// Scene register server.
// Input channel: i_in_valid / o_in_stall carry one request (t_in_req) per
// handshake. Output channel: o_out_valid / i_out_stall carry replies
// (t_out_res); a register reply is a run of results closed by last.
// One request is worked at a time; o_in_stall is high from acceptance until
// the request's work is done. A store, delete or recall with a nonzero scene
// still takes the scan of the table when it gives no reply.
// The scan reads and compares the stored scenes in turn, up to the first one
// not below the requested number. A store then shifts the entries above the
// slot up, each a read and then a write, and a delete shifts them down; a
// reply to get register, or to an acknowledged store or delete, lists the
// scenes held, one read and one result per scene.
// Reset clears the scene count, the current scene and the transaction key;
// the table needs no clearing. A stalled result holds in the output register
// and the request's work waits behind it; the next request may be accepted
// while the last result still waits.
module scene_register_server_core
    import srs_pkg::*;
#(
    parameter int SCENE_MAX = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    srs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    srs_datapath #(
        .SCENE_MAX (SCENE_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ hw/rtl/srs_checker.sv @@
module srs_checker
    import srs_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input t_in_req  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_res o_out_data
);

    // Hold a stalled request
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled request changed");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // A scene reply is a single closed result with no entry
    a_scene_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.reply_kind == KIND_SCENE) |->
            o_out_data.last && !o_out_data.entry_valid
            && (o_out_data.listed_scene == 16'd0))
        else $error("malformed scene reply");

    // An empty result always closes its run
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.entry_valid |-> o_out_data.last)
        else $error("empty result not last");

    // Full status only comes with a register reply
    a_full_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_FULL) |->
            (o_out_data.reply_kind == KIND_REGISTER))
        else $error("full status on scene reply");

endmodule

bind scene_register_server_core srs_checker u_srs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
